>>> sv/dtwsl_pkg.sv
// Shared types and constants for the DDS tuning-word serial loader.
package dtwsl_pkg;

  localparam int FREQ_W    = 17;
  localparam int TW_W      = 32;
  localparam int WORD_BITS = 40;
  localparam int DIGIT_W   = 16;
  localparam int DIGITS    = TW_W / DIGIT_W;
  localparam int CNT_W     = 6;

  localparam logic [1:0] KIND_RESET = 2'd0;
  localparam logic [1:0] KIND_WCLK  = 2'd1;
  localparam logic [1:0] KIND_FQUD  = 2'd2;

  localparam logic OP_RESET = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [FREQ_W-1:0] frequency_khz;
  } in_item_t;

  typedef struct packed {
    logic [1:0] pulse_kind;
    logic       data_bit;
    logic       last_pulse;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;      // capture clamped frequency, clear shift register
    logic       div_est;   // register reciprocal estimate of one quotient digit
    logic       div_rem;   // register partial remainder for that estimate
    logic       div_fix;   // correct digit by one if needed, shift it in
    logic       emit;      // write a pulse into the output register
    logic [1:0] kind;
    logic       use_data;  // data from shift register LSB, then shift right
    logic       last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

>>> sv/dds_tuning_word_serial_loader_top.sv
// Top level of the DDS tuning-word serial loader.
// Set-frequency: after accept, the divider forms two 16-bit digits in three steps each
//   (estimate, remainder, fix), then 41 pulses, one per cycle unless the output stalls.
// Reset command: 3 pulses.
// Next command taken the cycle after the last pulse enters the output register.
// Synchronous active-low reset returns the sequencer to idle and empties the output.
module dds_tuning_word_serial_loader_top #(
  parameter int REF_CLOCK_KHZ = 125000
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  dtwsl_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output dtwsl_pkg::out_item_t out_data
);

  dtwsl_pkg::dp_cmd_t cmd;
  dtwsl_pkg::dp_sts_t sts;

  dtwsl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_data.operation),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .sts          (sts)
  );

  dtwsl_datapath #(
    .REF_CLOCK_KHZ (REF_CLOCK_KHZ)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .frequency_khz (in_data.frequency_khz),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

>>> sv/dtwsl_ctrl.sv
// Sequencing state machine for the tuning-word loader.
module dtwsl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_operation,
  output logic                in_stall,
  output dtwsl_pkg::dp_cmd_t  cmd,
  input  dtwsl_pkg::dp_sts_t  sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_EST,
    ST_DIV_REM,
    ST_DIV_FIX,
    ST_SHIFT,
    ST_RST_PULSE,
    ST_RST_WCLK,
    ST_UPDATE
  } state_t;

  state_t                      state_r, state_nxt;
  logic [dtwsl_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.kind     = dtwsl_pkg::KIND_WCLK;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cnt_nxt  = '0;
          if (in_operation == dtwsl_pkg::OP_LOAD) begin
            state_nxt = ST_DIV_EST;
          end else begin
            state_nxt = ST_RST_PULSE;
          end
        end
      end
      ST_DIV_EST: begin
        cmd.div_est = 1'b1;
        state_nxt   = ST_DIV_REM;
      end
      ST_DIV_REM: begin
        cmd.div_rem = 1'b1;
        state_nxt   = ST_DIV_FIX;
      end
      ST_DIV_FIX: begin
        cmd.div_fix = 1'b1;
        if (cnt_r == dtwsl_pkg::CNT_W'(dtwsl_pkg::DIGITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SHIFT;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_DIV_EST;
        end
      end
      ST_SHIFT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.use_data = 1'b1;
          if (cnt_r == dtwsl_pkg::CNT_W'(dtwsl_pkg::WORD_BITS - 1)) begin
            cnt_nxt   = '0;
            state_nxt = ST_UPDATE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_RST_PULSE: begin
        cmd.kind = dtwsl_pkg::KIND_RESET;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_RST_WCLK;
        end
      end
      ST_RST_WCLK: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.kind = dtwsl_pkg::KIND_FQUD;
        cmd.last = 1'b1;
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("pulse emitted while output register occupied");

  a_last_is_update: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.last) |-> (cmd.kind == dtwsl_pkg::KIND_FQUD))
    else $error("last pulse is not an update pulse");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r != ST_IDLE))
    else $error("controller idle right after accepting a command");

  a_shift_after_divide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_FIX && state_nxt == ST_SHIFT)
      |-> (cnt_r == dtwsl_pkg::CNT_W'(dtwsl_pkg::DIGITS - 1)))
    else $error("division left before all quotient digits were formed");

endmodule

>>> sv/dtwsl_datapath.sv
// Clamp, reciprocal-multiply tuning-word divider, serial shift register and output register.
module dtwsl_datapath #(
  parameter int REF_CLOCK_KHZ = 125000
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [dtwsl_pkg::FREQ_W-1:0]        frequency_khz,
  input  dtwsl_pkg::dp_cmd_t                  cmd,
  output dtwsl_pkg::dp_sts_t                  sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dtwsl_pkg::out_item_t                out_data
);

  // Remainder always stays below the reference
  localparam int RW = $clog2(REF_CLOCK_KHZ);
  localparam int DG = dtwsl_pkg::DIGIT_W;
  localparam int PW = RW + DG + 1;
  localparam int CW = (dtwsl_pkg::FREQ_W > RW + 1) ? dtwsl_pkg::FREQ_W : RW + 1;
  localparam logic [CW-1:0] F_TOP    = CW'(REF_CLOCK_KHZ - 1);
  localparam logic [RW:0]   REF_VAL  = (RW + 1)'(REF_CLOCK_KHZ);
  localparam logic [PW-1:0] REF_WIDE = PW'(REF_CLOCK_KHZ);
  // floor(2^(DG+RW) / ref) fits DG+1 bits; the digit estimate is at most one short
  localparam logic [DG:0]   RECIP    =
    (DG + 1)'((64'd1 << (DG + RW)) / 64'(REF_CLOCK_KHZ));
  localparam int PAD = dtwsl_pkg::WORD_BITS - dtwsl_pkg::TW_W;

  logic [RW-1:0]                   rem_r;
  logic [DG-1:0]                   qest_r;
  logic [RW:0]                     rraw_r;
  logic [dtwsl_pkg::WORD_BITS-1:0] shift_r;
  logic                            out_valid_r;
  dtwsl_pkg::out_item_t            out_data_r;

  logic [CW-1:0] f_ext;
  logic [CW-1:0] f_clamp;
  logic [PW-1:0] prod_est;
  logic [PW-1:0] prod_back;
  logic [PW-1:0] rem_diff;
  logic [RW:0]   rem_sub;
  logic          q_fix;
  logic [DG-1:0] digit;

  assign f_ext     = CW'(frequency_khz);
  assign f_clamp   = (f_ext > F_TOP) ? F_TOP : f_ext;
  assign prod_est  = PW'(rem_r) * PW'(RECIP);
  assign prod_back = PW'(qest_r) * REF_WIDE;
  // true difference lies in [0, 2*ref)
  assign rem_diff  = {1'b0, rem_r, {DG{1'b0}}} - prod_back;
  assign q_fix     = (rraw_r >= REF_VAL);
  assign rem_sub   = rraw_r - REF_VAL;
  assign digit     = qest_r + {{(DG-1){1'b0}}, q_fix};

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r   <= f_clamp[RW-1:0];
      shift_r <= '0;
    end else if (cmd.div_fix) begin
      rem_r   <= q_fix ? rem_sub[RW-1:0] : rraw_r[RW-1:0];
      // digits arrive high first into the low 32 bits; control byte stays zero
      shift_r <= {{PAD{1'b0}}, shift_r[dtwsl_pkg::TW_W-DG-1:0], digit};
    end else if (cmd.emit && cmd.use_data) begin
      shift_r <= {1'b0, shift_r[dtwsl_pkg::WORD_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_est) begin
      qest_r <= prod_est[RW+DG-1:RW];
    end
    if (cmd.div_rem) begin
      rraw_r <= rem_diff[RW:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.pulse_kind <= cmd.kind;
      out_data_r.data_bit   <= cmd.use_data & shift_r[0];
      out_data_r.last_pulse <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

endmodule
